// ===== rtl/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation unit.
`default_nettype none
package mexp_pkg;

  localparam int MW   = 63;  // modulus and input field width
  localparam int VW   = 62;  // width of a residue
  localparam int CW   = 6;   // step counter width

  localparam logic [MW-1:0] MOD_LIMIT = {1'b1, {VW{1'b0}}};
  localparam logic [MW-1:0] MOD_RESET = 63'd1000000007;
  localparam logic [CW-1:0] REDUCE_LAST = 6'd62;  // 63 reduction steps
  localparam logic [CW-1:0] RUN_LAST    = 6'd61;  // 62 product steps

  // One modular product in flight: partial sum, doubled operand, multiplier bits.
  typedef struct packed {
    logic [VW-1:0] acc;
    logic [VW-1:0] dbl;
    logic [VW-1:0] y;
  } prod_tok_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LOOP,
    ST_RUN,
    ST_NEXT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/modular_exponentiation_unit.sv =====
// Top level of the modular exponentiation unit.
// Computes base^exponent mod modulus by right-to-left square-and-multiply, one
// item at a time. The base is first reduced by a restoring shift-subtract
// pass. For each exponent bit up to the highest set bit, the square and the
// multiply are loaded, circulate together through a ring of two shift-add
// cells for 62 steps, and are collected. A modulus of zero or one gives 0
// right away; a modulus above 2^62 is used as 2^62. The modulus may be
// written only while idle.
`default_nettype none
module modular_exponentiation_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [62:0]  cfg_data,       // modulus
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,   // [62:0] base, [125:63] exponent
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata    // [61:0] power
);
  import mexp_pkg::*;

  state_t        state, state_next;
  logic [MW-1:0] modulus;
  logic [MW-1:0] m_eff;
  logic [CW-1:0] cnt;
  logic [MW-1:0] b_sh;
  logic [MW-1:0] e;
  logic [VW-1:0] b;
  logic [VW-1:0] acc;
  logic [VW-1:0] result;
  logic [MW-1:0] rem_t;
  logic          in_acc;
  logic          out_write;
  logic          load;
  prod_tok_t     sq_load, mul_load, tok0, tok1;

  assign m_eff     = (modulus > MOD_LIMIT) ? MOD_LIMIT : modulus;
  assign cfg_ready = 1'b1;
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg_valid) begin
      modulus <= cfg_data;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (m_eff <= 63'd1) ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: if (cnt == '0) state_next = ST_LOOP;
      ST_LOOP:   state_next = (e == '0) ? ST_DONE : ST_RUN;
      ST_RUN:    if (cnt == '0) state_next = ST_NEXT;
      ST_NEXT:   state_next = ST_LOOP;
      ST_DONE:   if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    load          = 1'b0;
    out_write     = 1'b0;
    case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_LOOP: load = (e != '0);
      ST_DONE: out_write = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Restoring reduction step: remainder stays below m, so 62 bits hold it.
  always_comb begin
    rem_t = {b[VW-1:0], b_sh[MW-1]};
    if (rem_t >= m_eff) begin
      rem_t = rem_t - m_eff;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        b_sh   <= s_axis_tdata[62:0];
        e      <= s_axis_tdata[125:63];
        b      <= '0;
        acc    <= {{(VW-1){1'b0}}, 1'b1};
        result <= '0;
        cnt    <= REDUCE_LAST;
      end
      ST_REDUCE: begin
        b    <= rem_t[VW-1:0];
        b_sh <= {b_sh[MW-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
      end
      ST_LOOP: begin
        cnt    <= RUN_LAST;
        result <= acc;
      end
      ST_RUN: cnt <= cnt - 1'b1;
      ST_NEXT: begin
        b <= tok0.acc;
        if (e[0]) begin
          acc <= tok1.acc;
        end
        e <= {1'b0, e[MW-1:1]};
      end
      default: ;
    endcase
  end

  assign sq_load  = '{acc: '0, dbl: b,   y: b};
  assign mul_load = '{acc: '0, dbl: acc, y: b};

  // Two-cell ring: the square and the multiply swap cells every cycle and
  // after an even number of steps sit back where they were loaded.
  mexp_cell u_cell0 (
    .clk      (clk),
    .m        (m_eff),
    .load     (load),
    .load_tok (sq_load),
    .in_tok   (tok1),
    .out_tok  (tok0)
  );

  mexp_cell u_cell1 (
    .clk      (clk),
    .m        (m_eff),
    .load     (load),
    .load_tok (mul_load),
    .in_tok   (tok0),
    .out_tok  (tok1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_write) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_write) begin
      m_axis_tdata <= {2'b00, result};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mexp_cell.sv =====
// One shift-and-add cell of the product ring: a single step of x*y mod m.
`default_nettype none
module mexp_cell (
  input  wire logic                    clk,
  input  wire logic [mexp_pkg::MW-1:0] m,
  input  wire logic                    load,
  input  wire mexp_pkg::prod_tok_t     load_tok,
  input  wire mexp_pkg::prod_tok_t     in_tok,
  output mexp_pkg::prod_tok_t          out_tok
);
  import mexp_pkg::*;

  prod_tok_t     step;
  logic [MW-1:0] sum;
  logic [MW-1:0] dbl2;

  always_comb begin
    step = in_tok;
    sum  = {1'b0, in_tok.acc} + {1'b0, in_tok.dbl};
    if (sum >= m) begin
      sum = sum - m;
    end
    if (in_tok.y[0]) begin
      step.acc = sum[VW-1:0];
    end
    dbl2 = {in_tok.dbl, 1'b0};
    if (dbl2 >= m) begin
      dbl2 = dbl2 - m;
    end
    step.dbl = dbl2[VW-1:0];
    step.y   = {1'b0, in_tok.y[VW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok <= load_tok;
    end else begin
      out_tok <= step;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mexp_checker.sv =====
// Port-level checks for the modular exponentiation unit, bound to the top level.
`default_nettype none
module mexp_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         cfg_ready,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [63:0]  m_axis_tdata
);

  // A result waiting at the output is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  // Reset leaves no result pending.
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Only one item is at work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is at work");

  // A new result never lands on top of one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("waiting result overwritten");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (.*);
`default_nettype wire
